// ===== hdl/stm_pkg.sv =====
// shared types, opcodes and helpers for the sparse table range-maximum engine
`default_nettype none

package stm_pkg;

  localparam int unsigned DEPTH_DEF  = 1024;
  localparam int unsigned LEVELS_DEF = 11;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned OP_W       = 2;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]         opcode;
    logic signed [VAL_W-1:0] value;
    logic [IDX_W-1:0]        left_index;
    logic [IDX_W-1:0]        right_index;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] max_value;
    logic                    range_error;
  } out_item_t;

  function automatic logic signed [VAL_W-1:0] smax(input logic signed [VAL_W-1:0] a,
                                                   input logic signed [VAL_W-1:0] b);
    return (a >= b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/stm_mem.sv =====
// level table storage: one write port, two registered read ports
`default_nettype none

module stm_mem import stm_pkg::*; #(
  parameter int unsigned WORDS  = 2 * 2,
  parameter int unsigned ADDR_W = 2
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [VAL_W-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr_a,
  input  wire logic [ADDR_W-1:0] raddr_b,
  output logic      [VAL_W-1:0]  rdata_a,
  output logic      [VAL_W-1:0]  rdata_b
);

  logic [VAL_W-1:0] store_r [WORDS];
  logic [VAL_W-1:0] rdata_a_r;
  logic [VAL_W-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      store_r[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= store_r[raddr_a];
      rdata_b_r <= store_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

`default_nettype wire

// ===== hdl/sparse_table_range_max.sv =====
// top level of the sparse table range-maximum engine
//
// Input channel in_valid/in_stall/in_data carries append, query and clear
// commands; the output channel out_valid/out_stall/out_data carries one
// result per query. A transfer happens on a clock edge with valid high and
// stall low. One command is worked on at a time; in_stall is high while
// a command is in progress.
// Append: writes level 0 in the transfer cycle, then fills one level a
// cycle, reading the older half block from memory and taking the newer half
// from the value just written. The levels filled are the upper levels whose
// block now ends at the new position (at most LEVELS-1); each level is
// written back once its read data returns.
// Query: the transfer cycle issues both block reads; the query state then
// combines them into the output register once out_stall does not hold a
// previous result, and the next command can transfer after that.
// Clear and unused opcodes complete in the transfer cycle.
// The output register lets a new command start while a result waits. A query
// whose result cannot be loaded because out_stall holds the previous one
// waits in place, keeping its memory read data.
// Reset clears the element count and the control state; the table memory is
// not cleared, as no result uses an entry that is not loaded.
`default_nettype none

module sparse_table_range_max import stm_pkg::*; #(
  parameter int unsigned DEPTH  = DEPTH_DEF,
  parameter int unsigned LEVELS = LEVELS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned LW    = $clog2(LEVELS);
  localparam int unsigned KW    = $clog2(LEVELS + 1);
  localparam int unsigned PW    = ((IDX_W > CW) ? IDX_W : CW) + 1;
  localparam int unsigned MW    = LW + AW;
  localparam int unsigned WORDS = LEVELS << AW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_APPEND,
    ST_QUERY
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           p_r, p_nxt;
  logic [KW-1:0]           k_r, k_nxt;
  logic                    wpend_r, wpend_nxt;
  logic [LW-1:0]           wlvl_r, wlvl_nxt;
  logic [AW-1:0]           wpos_r, wpos_nxt;
  logic signed [VAL_W-1:0] fwd_r, fwd_nxt;
  logic                    qerr_r, qerr_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_item_t               out_data_r, out_data_nxt;

  logic             mem_we;
  logic [MW-1:0]    mem_waddr;
  logic [VAL_W-1:0] mem_wdata;
  logic             mem_re;
  logic [MW-1:0]    mem_raddr_a;
  logic [MW-1:0]    mem_raddr_b;
  logic [VAL_W-1:0] mem_rdata_a;
  logic [VAL_W-1:0] mem_rdata_b;

  // append step signals
  logic [CW-1:0]           p1_w;
  logic [CW-1:0]           start_w;
  logic                    app_go;
  logic signed [VAL_W-1:0] merged;

  // query decode signals
  logic [PW-1:0] lo_w, hi_w, cnt_w, len_w, second_w;
  logic [LW-1:0] q_lvl;
  logic          q_err;

  logic in_xfer;

  stm_mem #(
    .WORDS  (WORDS),
    .ADDR_W (MW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr_a (mem_raddr_a),
    .raddr_b (mem_raddr_b),
    .rdata_a (mem_rdata_a),
    .rdata_b (mem_rdata_b)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // level k block starting at p+1-2^k ends at the newest position
  always_comb begin
    p1_w    = CW'(p_r) + CW'(1);
    start_w = p1_w - (CW'(1) << k_r);
    app_go  = (k_r < KW'(LEVELS)) && ((p1_w >> k_r) != '0);
    merged  = smax($signed(mem_rdata_a), fwd_r);
  end

  // floor log2 of the range length, capped at the top level
  always_comb begin
    int unsigned lg;
    lg    = 0;
    lo_w  = PW'(in_data.left_index);
    hi_w  = PW'(in_data.right_index);
    cnt_w = PW'(count_r);
    len_w = hi_w - lo_w + PW'(1);
    for (int i = 0; i < PW; i++) begin
      if (len_w[i]) begin
        lg = i;
      end
    end
    if (lg > LEVELS - 1) begin
      lg = LEVELS - 1;
    end
    q_lvl    = LW'(lg);
    second_w = hi_w + PW'(1) - (PW'(1) << q_lvl);
    q_err    = (lo_w > hi_w) || (hi_w >= cnt_w);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    p_nxt         = p_r;
    k_nxt         = k_r;
    wpend_nxt     = 1'b0;
    wlvl_nxt      = wlvl_r;
    wpos_nxt      = wpos_r;
    fwd_nxt       = fwd_r;
    qerr_nxt      = qerr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr_a   = '0;
    mem_raddr_b   = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_data.opcode)
            OP_APPEND: begin
              if (count_r < CW'(DEPTH)) begin
                mem_we    = 1'b1;
                mem_waddr = {LW'(0), count_r[AW-1:0]};
                mem_wdata = in_data.value;
                fwd_nxt   = in_data.value;
                p_nxt     = count_r[AW-1:0];
                k_nxt     = KW'(1);
                count_nxt = count_r + CW'(1);
                state_nxt = ST_APPEND;
              end
            end
            OP_QUERY: begin
              mem_re      = 1'b1;
              mem_raddr_a = {q_lvl, lo_w[AW-1:0]};
              mem_raddr_b = {q_lvl, second_w[AW-1:0]};
              qerr_nxt    = q_err;
              state_nxt   = ST_QUERY;
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_APPEND: begin
        // write back the level whose read returned this cycle
        if (wpend_r) begin
          mem_we    = 1'b1;
          mem_waddr = {wlvl_r, wpos_r};
          mem_wdata = merged;
          fwd_nxt   = merged;
        end
        // the newer half is the block just written, so only the older half is read
        if (app_go) begin
          mem_re      = 1'b1;
          mem_raddr_a = {LW'(k_r - KW'(1)), start_w[AW-1:0]};
          wpend_nxt   = 1'b1;
          wlvl_nxt    = LW'(k_r);
          wpos_nxt    = start_w[AW-1:0];
          k_nxt       = k_r + KW'(1);
        end else begin
          state_nxt = ST_IDLE;
        end
      end

      ST_QUERY: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.range_error = qerr_r;
          out_data_nxt.max_value   = qerr_r ? '0
                                            : smax($signed(mem_rdata_a), $signed(mem_rdata_b));
          state_nxt                = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    k_r        <= k_nxt;
    wlvl_r     <= wlvl_nxt;
    wpos_r     <= wpos_nxt;
    fwd_r      <= fwd_nxt;
    qerr_r     <= qerr_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wpend_r     <= wpend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count beyond table depth");

  a_query_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QUERY && out_valid_r && out_stall) |=> (state_r == ST_QUERY))
    else $error("query result dropped while output stalled");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QUERY) |-> !mem_we)
    else $error("table write during query");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !wpend_r)
    else $error("pending level write left behind");

  a_result_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_QUERY))
    else $error("result without query");
`endif

endmodule

`default_nettype wire

// ===== tb/range_max_sb_pkg.sv =====
// scoreboard class holding the expected range-maximum results
package range_max_sb_pkg;
  import stm_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  class range_max_scoreboard;
    logic signed [VAL_W-1:0] level_q [LEVELS_DEF][DEPTH_DEF];
    int unsigned loaded = 0;
    int unsigned errors = 0;
    out_item_t awaited [$];

    // update the table copy for an accepted command and queue any result
    function void note_command(in_item_t cmd);
      int unsigned p, k, start, half, span_len, lo, hi;
      logic signed [VAL_W-1:0] a, b;
      out_item_t want;
      case (cmd.opcode)
        OP_APPEND: begin
          if (loaded < DEPTH_DEF) begin
            p = loaded;
            level_q[0][p] = cmd.value;
            // each level gains the one block that now ends at p
            for (k = 1; k < LEVELS_DEF && p + 1 >= (1 << k); k++) begin
              start = p + 1 - (1 << k);
              half  = 1 << (k - 1);
              a = level_q[k-1][start];
              b = level_q[k-1][start+half];
              level_q[k][start] = (a >= b) ? a : b;
            end
            loaded = p + 1;
          end
        end
        OP_QUERY: begin
          lo = cmd.left_index;
          hi = cmd.right_index;
          want = '0;
          if (lo > hi || hi >= loaded) begin
            want.range_error = 1'b1;
          end else begin
            span_len = hi - lo + 1;
            k = 0;
            while ((2 << k) <= span_len) k++;
            if (k > LEVELS_DEF - 1) k = LEVELS_DEF - 1;
            a = level_q[k][lo];
            b = level_q[k][hi + 1 - (1 << k)];
            want.max_value = (a >= b) ? a : b;
          end
          awaited.push_back(want);
        end
        OP_CLEAR: begin
          loaded = 0;
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(out_item_t got, time stamp);
      out_item_t want;
      if (awaited.size() == 0) begin
        $display("%0d ns: unexpected result, expected none, actual max_value %0d range_error %0b",
                 stamp, got.max_value, got.range_error);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.max_value !== want.max_value) begin
        $display("%0d ns: max_value expected %0d actual %0d",
                 stamp, want.max_value, got.max_value);
        errors++;
      end
      if (got.range_error !== want.range_error) begin
        $display("%0d ns: range_error expected %0b actual %0b",
                 stamp, want.range_error, got.range_error);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

endpackage

// ===== tb/testbench.sv =====
// top-level testbench driving the sparse table range-maximum engine
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import stm_pkg::*;
  import range_max_sb_pkg::*;

  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  range_max_scoreboard sb = new();
  int unsigned gap_odds   = 0;
  int unsigned stall_odds = 0;
  int unsigned counted    = 0;
  bit          hold_req   = 1'b0;

  sparse_table_range_max DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("sparse_table_range_max regression: fail");
    $finish;
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data, $time);
  end

  function automatic in_item_t make_cmd(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] v,
                                        logic [IDX_W-1:0] l, logic [IDX_W-1:0] r);
    in_item_t c;
    c.opcode      = op;
    c.value       = v;
    c.left_index  = l;
    c.right_index = r;
    return c;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return $signed($urandom_range(0, 16)) - 8;
      default: return $urandom();
    endcase
  endfunction

  // offer one command and hold it until the transfer
  task automatic send_cmd(in_item_t item);
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (item.opcode != OP_UNUSED && !(item.opcode == OP_APPEND && sb.loaded >= DEPTH_DEF))
      counted++;
    sb.note_command(item);
  endtask

  task automatic append_elem(logic signed [VAL_W-1:0] v);
    send_cmd(make_cmd(OP_APPEND, v, IDX_W'($urandom), IDX_W'($urandom)));
  endtask

  task automatic query_span(int unsigned l, int unsigned r);
    send_cmd(make_cmd(OP_QUERY, $urandom, IDX_W'(l), IDX_W'(r)));
  endtask

  task automatic clear_count();
    send_cmd(make_cmd(OP_CLEAR, $urandom, IDX_W'($urandom), IDX_W'($urandom)));
  endtask

  task automatic send_unused();
    send_cmd(make_cmd(OP_UNUSED, $urandom, IDX_W'($urandom), IDX_W'($urandom)));
  endtask

  // mostly ranges inside the loaded part, some malformed ones
  task automatic random_query();
    int unsigned n, l, r, k, len;
    n = sb.loaded;
    if (n == 0 || $urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: begin
          l = $urandom_range(1, DEPTH_DEF - 1);
          r = $urandom_range(0, l - 1);
        end
        1: begin
          r = (n >= DEPTH_DEF) ? DEPTH_DEF - 1 : $urandom_range(n, DEPTH_DEF - 1);
          l = $urandom_range(0, r);
        end
        default: begin
          l = $urandom_range(0, DEPTH_DEF - 1);
          r = $urandom_range(0, DEPTH_DEF - 1);
        end
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          l = 0;
          r = n - 1;
        end
        1: begin
          r = $urandom_range(0, n - 1);
          l = r;
        end
        2: begin
          // exact power-of-two span, a single block on one level
          k = $urandom_range(0, LEVELS_DEF - 1);
          while ((1 << k) > n) k--;
          len = 1 << k;
          l = $urandom_range(0, n - len);
          r = l + len - 1;
        end
        default: begin
          r = $urandom_range(0, n - 1);
          l = $urandom_range(0, r);
        end
      endcase
    end
    query_span(l, r);
  endtask

  // withdraw the last transfer first, then wait for every awaited result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned round_no, target, appended, extra, i;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, malformed ranges, clear and reuse
    query_span(0, 0);
    append_elem(VAL_MIN);
    query_span(0, 0);
    append_elem(VAL_MAX);
    append_elem(-1);
    append_elem(0);
    append_elem(VAL_MIN);
    query_span(0, 4);
    query_span(1, 1);
    query_span(2, 3);
    query_span(3, 1);
    query_span(0, 5);
    query_span(DEPTH_DEF - 1, DEPTH_DEF - 1);
    send_unused();
    query_span(2, 4);
    clear_count();
    query_span(0, 0);
    append_elem(5);
    query_span(0, 0);
    append_elem(5);
    query_span(0, 1);
    query_span(DEPTH_DEF - 1, 0);
    drain();

    round_no = 0;
    while (counted < 1900) begin
      round_no++;
      if (counted >= 1700) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
        stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 12);
      end
      clear_count();
      if (round_no == 4) target = DEPTH_DEF + 2;
      else if ($urandom_range(0, 9) == 0) target = $urandom_range(41, 300);
      else target = $urandom_range(1, 40);
      // appends past a full table count here too, the engine drops them
      appended = 0;
      while (appended < target) begin
        if (appended != 0 && $urandom_range(0, (round_no == 4) ? 7 : 2) == 0) begin
          random_query();
        end else if ($urandom_range(0, 60) == 0) begin
          send_unused();
        end else begin
          append_elem(pick_value());
          appended++;
        end
      end
      if (round_no == 4) begin
        query_span(0, DEPTH_DEF - 1);
        query_span(DEPTH_DEF - 1, DEPTH_DEF - 1);
        query_span(DEPTH_DEF / 2, DEPTH_DEF - 1);
      end
      // long output hold-off while queries keep coming in
      if (round_no == 3) hold_req = 1'b1;
      extra = (round_no == 3) ? 30 : $urandom_range(3, 20);
      for (i = 0; i < extra; i++) random_query();
      if (round_no == 3 || $urandom_range(0, 7) == 0) drain();
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sparse_table_range_max regression: pass");
    end else begin
      $display("sparse_table_range_max regression: fail");
    end
    $finish;
  end

endmodule
